// File: rtl/bcpe_pkg.sv
// Shared types and constants of the Bezier curve point evaluator.
package bcpe_pkg;

  // Curve parameter u: one integer bit and U_FRAC fraction bits.
  localparam int U_FRAC = 16;
  localparam int U_W    = U_FRAC + 1;
  localparam logic [U_W-1:0] U_ONE = U_W'(1) << U_FRAC;

  localparam int IDX_W  = 16;
  localparam int NCTL_W = 4;
  localparam int CFG_W  = 16;

  // Sequencer count: covers the divide steps and up to sixteen control points.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(U_FRAC);

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_EVAL_IDX  = 2'd1,
    OP_EVAL_NEXT = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  localparam logic CFG_NUM_CTRL   = 1'b0;
  localparam logic CFG_NUM_POINTS = 1'b1;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             div_step;
    logic             pinit;
    logic             pow_step;
    logic             pw;
    logic             mag;
    logic             cb;
    logic             acc;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
  } sts_t;

endpackage

// File: rtl/bcpe_in_if.sv
// Input channel: load or evaluate command word.
interface bcpe_in_if #(
  parameter int CW = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [2:0]                    ctrl_index;
  logic signed [CW-1:0]          in_x;
  logic signed [CW-1:0]          in_y;
  logic signed [CW-1:0]          in_z;
  logic [15:0]                   point_index;

  modport source (output valid, opcode, ctrl_index, in_x, in_y, in_z, point_index,
                  input ready);
  modport sink   (input valid, opcode, ctrl_index, in_x, in_y, in_z, point_index,
                  output ready);
endinterface

// File: rtl/bcpe_out_if.sv
// Output channel: evaluated curve point word.
interface bcpe_out_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic [15:0]          step_used;
  logic                 clamped;

  modport source (output valid, out_x, out_y, out_z, step_used, clamped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, step_used, clamped, output ready);
endinterface

// File: rtl/bcpe_ctrl.sv
// Sequencer state machine of the Bezier curve point evaluator.
module bcpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    opcode_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bcpe_pkg::sts_t sts_i,
  output bcpe_pkg::cmd_t cmd_o
);
  import bcpe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PINIT, ST_POW, ST_PW, ST_MAG, ST_CB, ST_ACC, ST_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept;
  logic             is_eval;
  logic             out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign is_eval     = (opcode_i == OP_EVAL_IDX) || (opcode_i == OP_EVAL_NEXT);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.cnt      = cnt_q;
    cmd_o.load     = accept && (opcode_i == OP_LOAD);
    cmd_o.start    = accept && is_eval;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.pinit    = (state_q == ST_PINIT);
    cmd_o.pow_step = (state_q == ST_POW);
    cmd_o.pw       = (state_q == ST_PW);
    cmd_o.mag      = (state_q == ST_MAG);
    cmd_o.cb       = (state_q == ST_CB);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.out_load = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || ((state_q == ST_OUT) && out_free);
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept && is_eval) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == DIV_LAST) begin
            state_q <= ST_PINIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PINIT: begin
          cnt_q   <= CNT_W'(1);
          state_q <= ST_POW;
        end
        ST_POW: begin
          if (cnt_q == sts_i.n) begin
            cnt_q   <= '0;
            state_q <= ST_PW;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PW:  state_q <= ST_MAG;
        ST_MAG: state_q <= ST_CB;
        ST_CB:  state_q <= ST_ACC;
        ST_ACC: begin
          if (cnt_q == sts_i.n) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_PW;
          end
        end
        ST_OUT: begin
          // Hold the finished point until the output register frees up.
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bcpe_dp.sv
// Datapath: control point store, u divider, power tables, weighted sum.
module bcpe_dp #(
  parameter int MAX_CTRL = 8,
  parameter int CW       = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bcpe_pkg::cmd_t               cmd_i,
  output bcpe_pkg::sts_t               sts_o,
  input  logic [1:0]                   opcode_i,
  input  logic [2:0]                   ctrl_index_i,
  input  logic signed [CW-1:0]         in_x_i,
  input  logic signed [CW-1:0]         in_y_i,
  input  logic signed [CW-1:0]         in_z_i,
  input  logic [bcpe_pkg::IDX_W-1:0]   point_index_i,
  input  logic [bcpe_pkg::NCTL_W-1:0]  num_ctrl_i,
  input  logic [bcpe_pkg::IDX_W-1:0]   num_points_i,
  output logic signed [CW-1:0]         out_x_o,
  output logic signed [CW-1:0]         out_y_o,
  output logic signed [CW-1:0]         out_z_o,
  output logic [bcpe_pkg::IDX_W-1:0]   step_used_o,
  output logic                         clamped_o
);
  import bcpe_pkg::*;

  localparam int CIW = $clog2(MAX_CTRL);
  localparam int BW  = MAX_CTRL - 1;
  localparam int SW  = CW + MAX_CTRL + 1;
  localparam int PW2 = 2 * U_W;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic signed [CW-1:0] st_q [3][MAX_CTRL];
  logic [BW-1:0]        binom_q [MAX_CTRL];
  logic [U_W-1:0]       pu_q [MAX_CTRL];
  logic [U_W-1:0]       pv_q [MAX_CTRL];

  logic [IDX_W-1:0] step_q, step_inc, step_d;
  logic [IDX_W-1:0] np, idx, idx_q, np_q;
  logic [CNT_W-1:0] nc, n_q, kb_full;
  logic [CIW-1:0]   ka, kb, ci;
  logic             clamp_q, ge;
  logic [U_W-1:0]   rem_q, rem_sub, quo_q, u_q, v_q, rpu_q, rpv_q, pw_q;
  logic [PW2-1:0]   mu, mv, mw;
  logic signed [CW-1:0] cpt [3];
  logic [CW-1:0]    mag_q [3];
  logic             neg_q [3];
  logic [CW+U_W-1:0] prod [3];
  logic [CW-1:0]    prod_q [3];
  logic [CW+BW-1:0] t_q [3];
  logic [BW-1:0]    cb_q;
  logic signed [SW-1:0] acc_q [3];
  logic signed [SW-1:0] term [3];
  logic signed [CW-1:0] sat [3];

  assign sts_o.n = n_q;

  // Effective point count and divisor, chosen when an evaluation starts.
  always_comb begin
    np  = (num_points_i == '0) ? IDX_W'(1) : num_points_i;
    idx = (opcode_i == OP_EVAL_NEXT) ? step_q : point_index_i;
    if (num_ctrl_i < NCTL_W'(2)) begin
      nc = CNT_W'(2);
    end else if (CNT_W'(num_ctrl_i) > CNT_W'(MAX_CTRL)) begin
      nc = CNT_W'(MAX_CTRL);
    end else begin
      nc = CNT_W'(num_ctrl_i);
    end
    step_inc = step_q + 1'b1;
    step_d   = (step_inc >= np) ? '0 : step_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.start && (opcode_i == OP_EVAL_NEXT)) begin
      step_q <= step_d;
    end
  end

  // Control point store.
  assign ci = CIW'(ctrl_index_i);
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(ctrl_index_i) < MAX_CTRL)) begin
      st_q[0][ci] <= in_x_i;
      st_q[1][ci] <= in_y_i;
      st_q[2][ci] <= in_z_i;
    end
  end

  // Restoring divider: u = idx * 2^16 / np, one quotient bit a cycle.
  assign ge      = rem_q >= {1'b0, np_q};
  assign rem_sub = ge ? (rem_q - {1'b0, np_q}) : rem_q;
  assign mu      = rpu_q * u_q;
  assign mv      = rpv_q * v_q;
  assign kb_full = n_q - cmd_i.cnt;
  assign ka      = cmd_i.cnt[CIW-1:0];
  assign kb      = kb_full[CIW-1:0];
  assign mw      = pu_q[ka] * pv_q[kb];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q   <= idx;
      np_q    <= np;
      n_q     <= nc - 1'b1;
      clamp_q <= idx > np;
      rem_q   <= {1'b0, idx};
      quo_q   <= '0;
      for (int j = 0; j < MAX_CTRL; j++) binom_q[j] <= (j == 0) ? BW'(1) : '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= {rem_sub[U_W-2:0], 1'b0};
      quo_q <= {quo_q[U_W-2:0], ge};
      // Advance one row of Pascal's triangle per cycle until row n.
      if (cmd_i.cnt < n_q) begin
        for (int j = 1; j < MAX_CTRL; j++) binom_q[j] <= binom_q[j] + binom_q[j-1];
      end
    end
    if (cmd_i.pinit) begin
      u_q      <= clamp_q ? U_ONE : quo_q;
      v_q      <= U_ONE - (clamp_q ? U_ONE : quo_q);
      rpu_q    <= U_ONE;
      rpv_q    <= U_ONE;
      pu_q[0]  <= U_ONE;
      pv_q[0]  <= U_ONE;
    end
    if (cmd_i.pow_step) begin
      rpu_q    <= mu[U_FRAC+U_W-1:U_FRAC];
      rpv_q    <= mv[U_FRAC+U_W-1:U_FRAC];
      pu_q[ka] <= mu[U_FRAC+U_W-1:U_FRAC];
      pv_q[ka] <= mv[U_FRAC+U_W-1:U_FRAC];
    end
    if (cmd_i.pw) begin
      pw_q <= mw[U_FRAC+U_W-1:U_FRAC];
      cb_q <= binom_q[ka];
    end
  end

  // Three coordinate lanes.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cpt[l]  = st_q[l][ka];
      prod[l] = mag_q[l] * pw_q;
      term[l] = $signed({2'b00, t_q[l]});
      if (acc_q[l] > SAT_HI) begin
        sat[l] = SAT_HI[CW-1:0];
      end else if (acc_q[l] < SAT_LO) begin
        sat[l] = SAT_LO[CW-1:0];
      end else begin
        sat[l] = acc_q[l][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (cmd_i.start) acc_q[l] <= '0;
      if (cmd_i.pw) begin
        neg_q[l] <= cpt[l][CW-1];
        mag_q[l] <= cpt[l][CW-1] ? (~cpt[l] + 1'b1) : cpt[l];
      end
      if (cmd_i.mag) prod_q[l] <= prod[l][U_FRAC+CW-1:U_FRAC];
      if (cmd_i.cb)  t_q[l]    <= prod_q[l] * cb_q;
      if (cmd_i.acc) acc_q[l]  <= neg_q[l] ? (acc_q[l] - term[l]) : (acc_q[l] + term[l]);
    end
    if (cmd_i.out_load) begin
      out_x_o     <= sat[0];
      out_y_o     <= sat[1];
      out_z_o     <= sat[2];
      step_used_o <= idx_q;
      clamped_o   <= clamp_q;
    end
  end

endmodule

// File: rtl/bezier_curve_point_eval_top.sv
// Top level of the Bezier curve point evaluator.
// Usage:
// - Words arrive on in_i (valid/ready). Opcode OP_LOAD writes control point
//   ctrl_index from in_x/in_y/in_z and produces no output word. OP_EVAL_IDX
//   evaluates at point_index, OP_EVAL_NEXT at the internal step counter,
//   which then advances and wraps at num_points. OP_NONE is dropped.
// - Each evaluation yields one word on out_o: the saturated Q16.16 point,
//   the step that was evaluated, and a clamp flag when the step ran past
//   num_points (u forced to one).
// - Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0: num_ctrl, 1: num_points); write only while the block is idle.
// - An evaluation runs as a 17-step restoring divide for u, N-1 power steps
//   on a shared multiplier pair for N control points in use, then the PW, MAG,
//   CB and ACC steps for each control point through the weighting multipliers
//   and accumulators. One evaluation is in flight.
// - The next word is accepted while a finished point waits in the output
//   register; if the receiver stalls, a second finished point holds in the
//   sequencer until the register frees up.
// - Reset clears the step counter, sets num_ctrl to 4 and num_points to 64.
//   Control points are undefined until loaded.
module bezier_curve_point_eval_top #(
  parameter int MAX_CTRL    = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bcpe_in_if.sink                     in_i,
  bcpe_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bcpe_pkg::CFG_W-1:0]  cfg_data_i
);
  import bcpe_pkg::*;

  logic [NCTL_W-1:0] num_ctrl_q;
  logic [IDX_W-1:0]  num_points_q;
  cmd_t              cmd;
  sts_t              sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ctrl_q   <= NCTL_W'(4);
      num_points_q <= IDX_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_CTRL:   num_ctrl_q   <= cfg_data_i[NCTL_W-1:0];
        CFG_NUM_POINTS: num_points_q <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  bcpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcpe_dp #(
    .MAX_CTRL (MAX_CTRL),
    .CW       (COORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_i.opcode),
    .ctrl_index_i  (in_i.ctrl_index),
    .in_x_i        (in_i.in_x),
    .in_y_i        (in_i.in_y),
    .in_z_i        (in_i.in_z),
    .point_index_i (in_i.point_index),
    .num_ctrl_i    (num_ctrl_q),
    .num_points_i  (num_points_q),
    .out_x_o       (out_o.out_x),
    .out_y_o       (out_o.out_y),
    .out_z_o       (out_o.out_z),
    .step_used_o   (out_o.step_used),
    .clamped_o     (out_o.clamped)
  );

  // An accepted evaluation occupies the sequencer on the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready &&
    (in_i.opcode == OP_EVAL_IDX || in_i.opcode == OP_EVAL_NEXT) |=> !in_i.ready)
    else $error("input still ready after accepting an evaluation");

  // A load leaves the input channel ready on the next cycle.
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.opcode == OP_LOAD |=> in_i.ready)
    else $error("load held the input channel");

  // A new point only comes from a running evaluation.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("output word appeared without an evaluation");

endmodule

// File: tb/bcpe_scoreboard.sv
// Scoreboard of the Bezier curve point evaluator: curve point predictor and checker.
`timescale 1ns / 100ps

class bcpe_scoreboard;
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        step;
    logic               clamp;
  } curve_point_t;

  logic signed [31:0] ctrl_x [8];
  logic signed [31:0] ctrl_y [8];
  logic signed [31:0] ctrl_z [8];
  logic [5:0]         binom [8];
  logic [15:0]        step_cnt;
  logic [3:0]         num_ctrl;
  logic [15:0]        num_points;
  curve_point_t       pending_points[$];
  int                 mismatches;

  function new();
    for (int k = 0; k < 8; k++) begin
      ctrl_x[k] = 0;
      ctrl_y[k] = 0;
      ctrl_z[k] = 0;
    end
    step_cnt   = 0;
    num_points = 64;
    mismatches = 0;
    set_num_ctrl(4);
  endfunction

  function int ctrl_used();
    if (num_ctrl < 2) return 2;
    if (num_ctrl > 8) return 8;
    return num_ctrl;
  endfunction

  // Rebuild the binomial row by Pascal's rule.
  function void set_num_ctrl(logic [3:0] v);
    int n;
    num_ctrl = v;
    n = ctrl_used() - 1;
    for (int k = 0; k < 8; k++) binom[k] = 0;
    binom[0] = 1;
    for (int r = 1; r <= n; r++)
      for (int k = r; k >= 1; k--) binom[k] = binom[k] + binom[k-1];
  endfunction

  function void set_num_points(logic [15:0] v);
    num_points = v;
  endfunction

  // Term rounds toward zero: magnitude times weight, truncate, scale, resign.
  function longint weigh(logic signed [31:0] c, longint unsigned pw, longint unsigned cb);
    longint unsigned mag;
    longint unsigned t;
    mag = c < 0 ? longint'(-longint'(c)) : longint'(c);
    t = ((mag * pw) >> 16) * cb;
    return c < 0 ? -longint'(t) : longint'(t);
  endfunction

  function logic signed [31:0] saturate(longint s);
    if (s > 64'sd2147483647) return 32'h7fffffff;
    if (s < -64'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  function curve_point_t eval_point(logic [15:0] idx);
    curve_point_t r;
    longint unsigned np, u, v, pw;
    longint unsigned pu [8];
    longint unsigned pv [8];
    longint sx, sy, sz;
    int nc;
    np = num_points == 0 ? 1 : num_points;
    nc = ctrl_used();
    r.clamp = idx > np;
    u = r.clamp ? 65536 : ((longint'(idx) << 16) / np);
    v = 65536 - u;
    pu[0] = 65536;
    pv[0] = 65536;
    for (int k = 1; k < nc; k++) begin
      pu[k] = (pu[k-1] * u) >> 16;
      pv[k] = (pv[k-1] * v) >> 16;
    end
    sx = 0;
    sy = 0;
    sz = 0;
    for (int k = 0; k < nc; k++) begin
      pw = (pu[k] * pv[nc-1-k]) >> 16;
      sx += weigh(ctrl_x[k], pw, binom[k]);
      sy += weigh(ctrl_y[k], pw, binom[k]);
      sz += weigh(ctrl_z[k], pw, binom[k]);
    end
    r.px = saturate(sx);
    r.py = saturate(sy);
    r.pz = saturate(sz);
    r.step = idx;
    return r;
  endfunction

  // Note an accepted input word and queue the point it yields.
  function void note_input(bcpe_pkg::opcode_e op, logic [2:0] ci, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z, logic [15:0] pi);
    longint unsigned np;
    np = num_points == 0 ? 1 : num_points;
    case (op)
      bcpe_pkg::OP_LOAD: begin
        ctrl_x[ci] = x;
        ctrl_y[ci] = y;
        ctrl_z[ci] = z;
      end
      bcpe_pkg::OP_EVAL_IDX: pending_points.push_back(eval_point(pi));
      bcpe_pkg::OP_EVAL_NEXT: begin
        pending_points.push_back(eval_point(step_cnt));
        step_cnt = step_cnt + 1;
        if (step_cnt >= np) step_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  task check_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                   logic [15:0] st, logic cl);
    curve_point_t e;
    if (pending_points.size() == 0) begin
      report("unexpected point", st, 0);
      return;
    end
    e = pending_points.pop_front();
    if (x !== e.px) report("out_x", x, e.px);
    if (y !== e.py) report("out_y", y, e.py);
    if (z !== e.pz) report("out_z", z, e.pz);
    if (st !== e.step) report("step_used", st, e.step);
    if (cl !== e.clamp) report("clamped", cl, e.clamp);
  endtask
endclass

// File: tb/bezier_curve_point_eval_top_test.sv
// Testbench top: drives commands and configuration, checks curve points.
`timescale 1ns / 100ps

module bezier_curve_point_eval_top_test;
  import bcpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // Idle odds in percent for each side, and the long hold-off request.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  bit  timed_out = 1'b0;
  int  quiet_cycles = 0;
  logic [7:0] ctrl_written = '0;

  bcpe_in_if  #(.CW(32)) in_ch ();
  bcpe_out_if #(.CW(32)) out_ch ();
  bcpe_scoreboard curve_sb;

  bezier_curve_point_eval_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.ctrl_index = '0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    in_ch.point_index = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: stall at random, or hold off entirely on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted point word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      curve_sb.check_point(out_ch.out_x, out_ch.out_y, out_ch.out_z,
                           out_ch.step_used, out_ch.clamped);
  end

  // Watchdog: count cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one command word; hold until accepted, then note it.
  // Valid stays high after acceptance; the next idle gap or drain drops it.
  task send_word(opcode_e op, logic [2:0] ci, logic [31:0] x, logic [31:0] y,
                 logic [31:0] z, logic [15:0] pi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.ctrl_index <= ci;
    in_ch.in_x <= x;
    in_ch.in_y <= y;
    in_ch.in_z <= z;
    in_ch.point_index <= pi;
    do @(posedge clk_i); while (!in_ch.ready);
    curve_sb.note_input(op, ci, x, y, z, pi);
    if (op == OP_LOAD) ctrl_written[ci] = 1'b1;
  endtask

  task load_point(logic [2:0] ci, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(OP_LOAD, ci, x, y, z, 16'($urandom));
  endtask

  // Wait until every prediction has come back, then let the sequencer drain.
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (curve_sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task write_cfg(logic idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_CTRL) curve_sb.set_num_ctrl(data[3:0]);
    else curve_sb.set_num_points(data);
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Random word: evaluate only where every control point in use was written.
  task random_word();
    int r;
    logic [15:0] pi;
    logic [7:0] need;
    r = $urandom_range(99);
    need = 8'hff >> (8 - curve_sb.ctrl_used());
    pi = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(curve_sb.num_points + 2));
    if (r < 30 || (ctrl_written & need) != need)
      load_point(3'($urandom_range(7)), rand_coord(), rand_coord(), rand_coord());
    else if (r < 60) send_word(OP_EVAL_IDX, 3'($urandom), $urandom, $urandom, $urandom, pi);
    else if (r < 95) send_word(OP_EVAL_NEXT, 3'($urandom), $urandom, $urandom, $urandom, pi);
    else send_word(OP_NONE, 3'($urandom), $urandom, $urandom, $urandom, pi);
  endtask

  initial begin
    int nc_vals [5] = '{2, 8, 5, 0, 15};
    int np_vals [5] = '{1, 65535, 7, 0, 300};
    curve_sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, extreme coordinates, edge indexes, every opcode.
    for (int k = 0; k < 8; k++)
      load_point(3'(k), k[0] ? 32'h7fffffff : 32'h80000000, 32'h00010000, k * 32'h11111);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'd0);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'd32);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'd64);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'd65);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'hffff);
    send_word(OP_NONE, 7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
    send_word(OP_EVAL_NEXT, 0, 0, 0, 0, 0);
    send_word(OP_EVAL_NEXT, 0, 0, 0, 0, 0);
    load_point(3, 32'hffffffff, 32'h7fffffff, 32'h80000000);
    send_word(OP_EVAL_IDX, 0, 0, 0, 0, 16'd16);
    drain();
    // Shrink num_points below the step counter: next step evaluates clamped.
    for (int k = 0; k < 60; k++) send_word(OP_EVAL_NEXT, 0, 0, 0, 0, 0);
    drain();
    write_cfg(CFG_NUM_POINTS, 16'd3);
    send_word(OP_EVAL_NEXT, 0, 0, 0, 0, 0);
    send_word(OP_EVAL_NEXT, 0, 0, 0, 0, 0);
    drain();

    // Random phases over configurations and idling patterns.
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_NUM_CTRL, 16'(nc_vals[ph % 5]));
      write_cfg(CFG_NUM_POINTS, 16'(np_vals[(ph + 2) % 5]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (ph == 4) begin
        // Long receiver hold-off while the sender keeps offering words.
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
          for (int i = 0; i < 100; i++) random_word();
        join
      end else begin
        for (int i = 0; i < 100; i++) random_word();
      end
      drain();
    end

    if (curve_sb.mismatches == 0 && curve_sb.pending_points.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
